// ===== sv/swfd_pkg.sv =====
package swfd_pkg;

    // Stream constants.
    localparam logic [31:0] SYNC_WORD        = 32'h2ef0_7a08;
    localparam int          MAX_CHANNELS     = 1024;
    localparam int          FRAMES_PER_BLOCK = 128;

    // Fixed field widths.
    localparam int BYTE_W      = 8;
    localparam int CFG_W       = 11;
    localparam int CHAN_IDX_W  = 10;
    localparam int FRAME_IDX_W = 7;
    localparam int VALUE_W     = 32;

    // Width of the field slot counter: timestamp slot plus one per channel.
    localparam int SLOT_W = CFG_W;

    localparam logic [CFG_W-1:0] MAX_CHANNELS_C = CFG_W'(MAX_CHANNELS);
    localparam logic [FRAME_IDX_W-1:0] LAST_FRAME = FRAME_IDX_W'(FRAMES_PER_BLOCK - 1);

    // Field kinds.
    localparam logic KIND_TIMESTAMP = 1'b0;
    localparam logic KIND_SAMPLE    = 1'b1;

    // Parser mode.
    typedef enum logic {
        MODE_HUNT,
        MODE_FRAMES
    } t_mode;

    // One completed field.
    typedef struct packed {
        logic                   field_kind;
        logic [CHAN_IDX_W-1:0]  channel_index;
        logic [FRAME_IDX_W-1:0] frame_index;
        logic [VALUE_W-1:0]     field_value;
        logic                   block_last;
    } t_field;

endpackage

// ===== sv/swfd_parser.sv =====
module swfd_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [swfd_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                       i_take,
    input  logic [swfd_pkg::BYTE_W-1:0] i_byte,
    output logic                       o_emit,
    output swfd_pkg::t_field           o_field
);
    import swfd_pkg::*;

    t_mode                  r_mode, n_mode;
    logic [CFG_W-1:0]       r_cfg_count;
    logic [CFG_W-1:0]       r_chan_now, n_chan_now;
    logic [23:0]            r_window, n_window;
    logic [1:0]             r_fill, n_fill;
    logic [FRAME_IDX_W-1:0] r_frame, n_frame;
    logic [1:0]             r_pos, n_pos;
    logic [23:0]            r_partial, n_partial;
    logic [SLOT_W-1:0]      r_slot, n_slot;

    logic                   sync_hit;
    logic                   field_end;
    logic                   frame_done;
    logic [CFG_W-1:0]       clamped;
    logic [SLOT_W-1:0]      chan_sub;

    // Configuration register, latched into the block at sync.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count <= '0;
        end else if (i_cfg_we) begin
            r_cfg_count <= i_cfg_wdata;
        end
    end

    assign clamped    = (r_cfg_count > MAX_CHANNELS_C) ? MAX_CHANNELS_C : r_cfg_count;
    assign sync_hit   = (r_fill == 2'd3) && ({i_byte, r_window} == SYNC_WORD);
    assign field_end  = (r_slot == '0) ? (r_pos == 2'd3) : (r_pos == 2'd1);
    assign frame_done = (r_slot >= r_chan_now);
    assign chan_sub   = r_slot - SLOT_W'(1);

    // Next mode.
    always_comb begin
        n_mode = r_mode;
        if (i_take) begin
            unique case (r_mode)
                MODE_HUNT: begin
                    if (sync_hit) begin
                        n_mode = MODE_FRAMES;
                    end
                end
                MODE_FRAMES: begin
                    if (field_end && frame_done && (r_frame == LAST_FRAME)) begin
                        n_mode = MODE_HUNT;
                    end
                end
                default: n_mode = MODE_HUNT;
            endcase
        end
    end

    // Datapath state and the emitted field.
    always_comb begin
        n_chan_now = r_chan_now;
        n_window   = r_window;
        n_fill     = r_fill;
        n_frame    = r_frame;
        n_pos      = r_pos;
        n_partial  = r_partial;
        n_slot     = r_slot;
        o_emit     = 1'b0;

        o_field.frame_index = r_frame;
        o_field.block_last  = frame_done && (r_frame == LAST_FRAME);
        if (r_slot == '0) begin
            o_field.field_kind    = KIND_TIMESTAMP;
            o_field.channel_index = '0;
            o_field.field_value   = {i_byte, r_partial};
        end else begin
            o_field.field_kind    = KIND_SAMPLE;
            o_field.channel_index = chan_sub[CHAN_IDX_W-1:0];
            o_field.field_value   = {16'd0, i_byte, r_partial[7:0]};
        end

        if (i_take) begin
            unique case (r_mode)
                MODE_HUNT: begin
                    if (r_fill != 2'd3) begin
                        // Window still filling from empty.
                        case (r_fill)
                            2'd0:    n_window[7:0]   = i_byte;
                            2'd1:    n_window[15:8]  = i_byte;
                            default: n_window[23:16] = i_byte;
                        endcase
                        n_fill = r_fill + 2'd1;
                    end else if (sync_hit) begin
                        n_chan_now = clamped;
                        n_window   = '0;
                        n_fill     = '0;
                        n_frame    = '0;
                        n_pos      = '0;
                        n_partial  = '0;
                        n_slot     = '0;
                    end else begin
                        n_window = {i_byte, r_window[23:8]};
                    end
                end
                MODE_FRAMES: begin
                    if (!field_end) begin
                        // Gather one more byte of the current field.
                        case (r_pos)
                            2'd0:    n_partial[7:0]   = i_byte;
                            2'd1:    n_partial[15:8]  = i_byte;
                            default: n_partial[23:16] = i_byte;
                        endcase
                        n_pos = r_pos + 2'd1;
                    end else begin
                        o_emit    = 1'b1;
                        n_pos     = '0;
                        n_partial = '0;
                        if (frame_done) begin
                            n_slot = '0;
                            if (r_frame == LAST_FRAME) begin
                                n_window = '0;
                                n_fill   = '0;
                                n_frame  = '0;
                            end else begin
                                n_frame = r_frame + FRAME_IDX_W'(1);
                            end
                        end else begin
                            n_slot = r_slot + SLOT_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_HUNT;
            r_chan_now <= '0;
            r_window   <= '0;
            r_fill     <= '0;
            r_frame    <= '0;
            r_pos      <= '0;
            r_partial  <= '0;
            r_slot     <= '0;
        end else begin
            r_mode     <= n_mode;
            r_chan_now <= n_chan_now;
            r_window   <= n_window;
            r_fill     <= n_fill;
            r_frame    <= n_frame;
            r_pos      <= n_pos;
            r_partial  <= n_partial;
            r_slot     <= n_slot;
        end
    end

endmodule

// ===== sv/swfd_out_reg.sv =====
module swfd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  swfd_pkg::t_field i_field,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output swfd_pkg::t_field o_field
);
    import swfd_pkg::*;

    logic   r_valid;
    t_field r_field;

    // The register can take a new field when empty or when its field leaves now.
    assign o_space = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_load) begin
            r_field <= i_field;
        end
    end

    assign o_valid = r_valid;
    assign o_field = r_field;

endmodule

// ===== sv/sync_word_frame_deframer_top.sv =====
// Channel   | Direction | Signals
// ----------+-----------+-------------------------------------------------------
// rx        | in        | i_rx_valid, o_rx_ready, i_rx_byte
// out       | out       | o_out_valid, i_out_ready, o_field_kind, o_channel_index,
//           |           | o_frame_index, o_field_value, o_block_last
// cfg       | in        | i_cfg_we, i_cfg_wdata (channel count)
//
// One byte is taken per cycle while ready is high; a completed field shows
// in the cycle after its last byte is taken, in the single output register.
// Input ready is low only while that register is full and not being taken.
// Reset is synchronous and active low; it returns the parser to hunting with
// an empty window and clears the channel count.
module sync_word_frame_deframer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [swfd_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic                                i_rx_valid,
    output logic                                o_rx_ready,
    input  logic [swfd_pkg::BYTE_W-1:0]         i_rx_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_field_kind,
    output logic [swfd_pkg::CHAN_IDX_W-1:0]     o_channel_index,
    output logic [swfd_pkg::FRAME_IDX_W-1:0]    o_frame_index,
    output logic [swfd_pkg::VALUE_W-1:0]        o_field_value,
    output logic                                o_block_last
);
    import swfd_pkg::*;

    logic   take;
    logic   space;
    logic   emit;
    t_field field_next;
    t_field field_out;

    assign o_rx_ready = space;
    assign take       = i_rx_valid && space;

    swfd_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_take     (take),
        .i_byte     (i_rx_byte),
        .o_emit     (emit),
        .o_field    (field_next)
    );

    swfd_out_reg u_out_reg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (emit),
        .i_field(field_next),
        .o_space(space),
        .o_valid(o_out_valid),
        .i_ready(i_out_ready),
        .o_field(field_out)
    );

    assign o_field_kind    = field_out.field_kind;
    assign o_channel_index = field_out.channel_index;
    assign o_frame_index   = field_out.frame_index;
    assign o_field_value   = field_out.field_value;
    assign o_block_last    = field_out.block_last;

endmodule
